FILE: hdl/ped_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ped_pkg
// shared widths, codes and types of the panel event decoder
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam int ENCODER_SLOTS_DEF = 32;

    localparam int EVENT_W    = 8;
    localparam int BASE_W     = 5;
    localparam int SLOT_SUM_W = 6;
    localparam int PIN_W      = 9;
    localparam int SLOT_OUT_W = 5;
    localparam int STEP_W     = 4;
    localparam int COUNT_W    = 32;
    localparam int DELTA_W    = 5;
    localparam int REG_W      = 6;
    localparam int ROW_W      = 3;

    localparam logic KIND_BUTTON  = 1'b0;
    localparam logic KIND_ENCODER = 1'b1;

    localparam logic MODE_FOUR_COL = 1'b0;
    localparam logic MODE_KEYPAD   = 1'b1;

    typedef logic signed [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic             level;
    } t_btn_res;

    typedef struct packed {
        logic                     changed;
        logic signed [STEP_W-1:0] step;
        t_count                   new_raw;
    } t_step_res;

endpackage
`default_nettype wire

FILE: hdl/ped_btn_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ped_btn_map
// maps a button event to shift-register pin number and level
// ----------------------------------------------------------------------------
module ped_btn_map (
    input  wire logic [ped_pkg::EVENT_W-1:0] i_event,
    input  wire logic                        i_mode,
    input  wire logic [ped_pkg::BASE_W-1:0]  i_base_register,
    output ped_pkg::t_btn_res                o_res
);
    import ped_pkg::*;

    logic [5:0]       button;
    logic [REG_W-1:0] sreg;
    logic [ROW_W-1:0] row;
    logic             level;

    assign button = i_event[6:1];

    always_comb begin
        unique case (i_mode)
            MODE_FOUR_COL: begin
                // reversed register order, inverted level
                sreg  = REG_W'(i_base_register) + REG_W'(3) - {2'b00, button[5:2]};
                row   = {1'b0, button[1:0]};
                level = ~i_event[0];
            end
            MODE_KEYPAD: begin
                sreg  = REG_W'(i_base_register) + {3'b000, button[5:3]};
                row   = button[2:0];
                level = i_event[0];
            end
            default: begin
                sreg  = '0;
                row   = '0;
                level = 1'b0;
            end
        endcase
    end

    assign o_res.pin   = {sreg, row};
    assign o_res.level = level;

endmodule
`default_nettype wire

FILE: hdl/ped_step_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ped_step_calc
// raw count update and saturated change of the reported count
// ----------------------------------------------------------------------------
module ped_step_calc (
    input  wire ped_pkg::t_count                    i_raw,
    input  wire logic [ped_pkg::DELTA_W-1:0]        i_delta,
    output ped_pkg::t_step_res                      o_res
);
    import ped_pkg::*;

    // divide by four, truncated toward zero
    function automatic t_count f_div4(input t_count x);
        t_count q;
        q = x >>> 2;
        return q + t_count'({1'b0, x[COUNT_W-1] & (x[1:0] != 2'b00)});
    endfunction

    t_count new_raw;
    t_count prev_rep;
    t_count new_rep;
    t_count diff;

    always_comb begin
        new_raw  = i_raw + {{(COUNT_W-DELTA_W){i_delta[DELTA_W-1]}}, i_delta};
        prev_rep = f_div4(i_raw);
        new_rep  = f_div4(new_raw);
        diff     = new_rep - prev_rep;
    end

    always_comb begin
        o_res.new_raw = new_raw;
        o_res.changed = (diff != '0);
        if (diff > 32'sd7) begin
            o_res.step = 4'sd7;
        end else if (diff < -32'sd8) begin
            o_res.step = -4'sd8;
        end else begin
            o_res.step = diff[STEP_W-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/ped_cnt_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ped_cnt_mem
// raw encoder counts, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ped_cnt_mem #(
    parameter  int ENCODER_SLOTS = ped_pkg::ENCODER_SLOTS_DEF,
    localparam int SLOT_W        = (ENCODER_SLOTS > 1) ? $clog2(ENCODER_SLOTS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [SLOT_W-1:0] i_rd_idx,
    input  wire logic            i_wr_en,
    input  wire logic [SLOT_W-1:0] i_wr_idx,
    input  wire ped_pkg::t_count i_wr_data,
    output ped_pkg::t_count      o_rd_data
);
    import ped_pkg::*;

    t_count                   r_mem [ENCODER_SLOTS];
    logic [ENCODER_SLOTS-1:0] r_vld;
    t_count                   r_rd_data;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            // bypass a write to the same slot at this edge
            if (i_wr_en && (i_wr_idx == i_rd_idx)) begin
                r_rd_data <= i_wr_data;
            end else if (r_vld[i_rd_idx]) begin
                r_rd_data <= r_mem[i_rd_idx];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: hdl/panel_event_decoder_detent_encoders.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted word is held in stage 1, then any result word in the output registers
// throughput: one word per cycle unless a held result stalls, set by the single count RMW
// the count memory is read at accept and written back as stage 1 fires, with a bypass
// reset: synchronous active-low reset empties both stages and marks every count slot as
// unwritten, so all counts read as zero right away; no clearing pass is needed
// ----------------------------------------------------------------------------
// panel_event_decoder_detent_encoders
// decodes panel event bytes into button pin changes and encoder step changes
// ----------------------------------------------------------------------------
module panel_event_decoder_detent_encoders #(
    parameter  int ENCODER_SLOTS = ped_pkg::ENCODER_SLOTS_DEF,
    localparam int SLOT_W        = (ENCODER_SLOTS > 1) ? $clog2(ENCODER_SLOTS) : 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [ped_pkg::EVENT_W-1:0]     i_event_byte,
    input  wire logic                            i_mode,
    input  wire logic [ped_pkg::BASE_W-1:0]      i_base_register,
    input  wire logic [ped_pkg::BASE_W-1:0]      i_base_encoder,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_kind,
    output logic [ped_pkg::PIN_W-1:0]            o_pin,
    output logic                                 o_pin_level,
    output logic [ped_pkg::SLOT_OUT_W-1:0]       o_encoder_slot,
    output logic signed [ped_pkg::STEP_W-1:0]    o_step_change
);
    import ped_pkg::*;

    localparam int CMP_W = 9;

    // ---------------------------------------------------------------- input side decode
    logic [SLOT_SUM_W-1:0] in_slot;
    logic [CMP_W-1:0]      in_slot_ext;
    logic                  in_hit;
    logic                  in_accept;

    // encoder slot is base plus the two encoder-select bits
    assign in_slot     = SLOT_SUM_W'(i_base_encoder) + {4'b0000, i_event_byte[6:5]};
    assign in_slot_ext = {{(CMP_W-SLOT_SUM_W){1'b0}}, in_slot};
    assign in_hit      = (in_slot_ext < CMP_W'(ENCODER_SLOTS));
    assign in_accept   = i_valid && o_ready;

    // ---------------------------------------------------------------- stage 1 registers
    logic                  r_s1_valid;
    logic [EVENT_W-1:0]    r_s1_ev;
    logic                  r_s1_mode;
    logic [BASE_W-1:0]     r_s1_base_reg;
    logic [SLOT_SUM_W-1:0] r_s1_slot;
    logic                  r_s1_hit;
    logic [SLOT_W-1:0]     r_s1_idx;

    // ---------------------------------------------------------------- output registers
    logic                     r_out_valid;
    logic                     r_out_kind;
    logic [PIN_W-1:0]         r_out_pin;
    logic                     r_out_level;
    logic [SLOT_OUT_W-1:0]    r_out_slot;
    logic signed [STEP_W-1:0] r_out_step;

    // ---------------------------------------------------------------- stage 1 logic
    t_count    s1_raw;
    t_btn_res  btn_res;
    t_step_res step_res;
    logic      s1_is_btn;
    logic      s1_is_enc;
    logic      s1_has_result;
    logic      s1_fire;
    logic      out_free;
    logic      cnt_wr_en;

    ped_btn_map u_btn_map (
        .i_event         (r_s1_ev),
        .i_mode          (r_s1_mode),
        .i_base_register (r_s1_base_reg),
        .o_res           (btn_res)
    );

    ped_step_calc u_step_calc (
        .i_raw   (s1_raw),
        .i_delta (r_s1_ev[DELTA_W-1:0]),
        .o_res   (step_res)
    );

    ped_cnt_mem #(
        .ENCODER_SLOTS (ENCODER_SLOTS)
    ) u_cnt_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept && in_hit),
        .i_rd_idx  (in_slot_ext[SLOT_W-1:0]),
        .i_wr_en   (cnt_wr_en),
        .i_wr_idx  (r_s1_idx),
        .i_wr_data (step_res.new_raw),
        .o_rd_data (s1_raw)
    );

    always_comb begin
        s1_is_btn     = r_s1_ev[EVENT_W-1];
        // zero byte is no event, slots past the table are ignored
        s1_is_enc     = !r_s1_ev[EVENT_W-1] && (r_s1_ev != '0) && r_s1_hit;
        s1_has_result = s1_is_btn || (s1_is_enc && step_res.changed);
        out_free      = !r_out_valid || i_ready;
        s1_fire       = r_s1_valid && (!s1_has_result || out_free);
        // raw count moves even when the reported count does not
        cnt_wr_en     = s1_fire && s1_is_enc;
        o_ready       = !r_s1_valid || s1_fire;
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && s1_has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ev       <= i_event_byte;
            r_s1_mode     <= i_mode;
            r_s1_base_reg <= i_base_register;
            r_s1_slot     <= in_slot;
            r_s1_hit      <= in_hit;
            r_s1_idx      <= in_slot_ext[SLOT_W-1:0];
        end
        if (s1_fire && s1_has_result) begin
            if (s1_is_btn) begin
                r_out_kind  <= KIND_BUTTON;
                r_out_pin   <= btn_res.pin;
                r_out_level <= btn_res.level;
                r_out_slot  <= '0;
                r_out_step  <= '0;
            end else begin
                r_out_kind  <= KIND_ENCODER;
                r_out_pin   <= '0;
                r_out_level <= 1'b0;
                r_out_slot  <= r_s1_slot[SLOT_OUT_W-1:0];
                r_out_step  <= step_res.step;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_pin          = r_out_pin;
    assign o_pin_level    = r_out_level;
    assign o_encoder_slot = r_out_slot;
    assign o_step_change  = r_out_step;

    // ---------------------------------------------------------------- assertions
    a_btn_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_BUTTON)) |-> (o_encoder_slot == '0) && (o_step_change == '0))
        else $error("button word carries encoder fields");

    a_enc_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_ENCODER)) |-> (o_pin == '0) && !o_pin_level
            && (o_step_change != '0))
        else $error("encoder word malformed");

    a_wr_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_wr_en |-> r_s1_valid && r_s1_hit && !r_s1_ev[EVENT_W-1])
        else $error("count write without a live encoder word");

    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_s1_valid) |-> s1_fire)
        else $error("stage 1 overwritten before it moved on");

    a_result_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_has_result) |=> o_valid)
        else $error("result word lost");

endmodule
`default_nettype wire
